@@ src/gtrs_pkg.sv @@
// Shared widths and constants for the gate timer range select block.
// No dependencies; used by every module in src.
`timescale 1ns / 1ps
`default_nettype none
package gtrs_pkg;

	// field widths
	localparam int FREQ_W  = 29;
	localparam int GATE_W  = 16;
	localparam int PROD_W  = FREQ_W + GATE_W;
	localparam int COUNT_W = 29;
	localparam int TMR_W   = 16;

	// scaling and selection constants
	localparam logic [GATE_W-1:0]  GATE_RESET   = GATE_W'(1000);
	localparam logic [TMR_W-1:0]   DIV_THOUSAND = TMR_W'(1000);
	localparam logic [PROD_W-1:0]  COUNT_LIMIT  = PROD_W'(288000000);
	localparam logic [COUNT_W-1:0] HYST_HIGH    = COUNT_W'(650000);
	localparam logic [COUNT_W-1:0] HYST_LOW     = COUNT_W'(640000);
	localparam int                 EDGE_SHIFT   = 3;
	localparam int                 PSC_SHIFT    = 16;

	// stored settings after reset
	localparam logic [TMR_W-1:0] PSC_RESET    = TMR_W'(45);
	localparam logic [TMR_W-1:0] RELOAD_RESET = TMR_W'(65535);

endpackage
`default_nettype wire

@@ src/gtrs_serial_mult.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on gtrs_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none
module gtrs_serial_mult #(
	parameter int A_W = gtrs_pkg::FREQ_W,
	parameter int B_W = gtrs_pkg::GATE_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [A_W-1:0]   a,
	input  wire logic [B_W-1:0]   b,
	output logic                  done,
	output logic [A_W+B_W-1:0]    product
);

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [P_W-1:0]   acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	// control: count multiplier bits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath: acc = 2*acc + (top bit of b ? a : 0)
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= {b_q[B_W-2:0], 1'b0};
			acc_q <= {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

@@ src/gtrs_serial_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on gtrs_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none
module gtrs_serial_div #(
	parameter int DVD_W = gtrs_pkg::PROD_W,
	parameter int DVS_W = gtrs_pkg::TMR_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath: dividend shifts out of the top while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ src/gate_timer_range_select.sv @@
// Gate timer range select: top level with the sequencer and stored settings.
// Depends on gtrs_pkg, gtrs_serial_mult and gtrs_serial_div.
//
// Each transfer on the input channel carries a frequency in hertz. The block
// forms count = frequency * gate_time_ms / 1000, rejects counts of 288000000
// and above, picks the edge prescaler (a shift by EDGE_SHIFT) with hysteresis, and
// derives the timer prescale and reload, returning one result per input. An
// accepted item goes through the bit-serial multiplier and then makes two
// passes through the one restoring divider (by 1000, then by prescale + 1);
// a rejected item skips the second division. in_stall is high while an item
// is being worked on; a finished result waits in the output register, so the
// next item may be taken while it is held. gate_time_ms is written through
// the cfg channel, which is always ready.
`timescale 1ns / 1ps
`default_nettype none
module gate_timer_range_select (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gtrs_pkg::GATE_W-1:0]   gate_time_ms,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [gtrs_pkg::FREQ_W-1:0]   frequency_hz,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               accepted,
	output logic                               divide_by_eight,
	output logic [gtrs_pkg::TMR_W-1:0]         timer_prescale,
	output logic [gtrs_pkg::TMR_W-1:0]         timer_reload,
	output logic                               changed
);

	localparam int PROD_W  = gtrs_pkg::PROD_W;
	localparam int COUNT_W = gtrs_pkg::COUNT_W;
	localparam int TMR_W   = gtrs_pkg::TMR_W;
	localparam int PSC_W   = COUNT_W - gtrs_pkg::PSC_SHIFT;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV1 = 5'b00100,
		ST_DIV2 = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [gtrs_pkg::GATE_W-1:0] gate_q;
	logic                        div8_q;
	logic [TMR_W-1:0]            psc_q;
	logic [TMR_W-1:0]            reload_q;
	logic [TMR_W-1:0]            new_psc_q;
	logic                        res_acc_q;
	logic                        res_chg_q;

	logic                        out_valid_q;
	logic                        out_acc_q;
	logic                        out_div8_q;
	logic [TMR_W-1:0]            out_psc_q;
	logic [TMR_W-1:0]            out_reload_q;
	logic                        out_chg_q;

	logic                        in_take;
	logic                        mul_done;
	logic [PROD_W-1:0]           product;
	logic                        div_start;
	logic [PROD_W-1:0]           div_dividend;
	logic [TMR_W-1:0]            div_divisor;
	logic                        div_done;
	logic [PROD_W-1:0]           div_quo;

	logic                        reject;
	logic [COUNT_W-1:0]          count;
	logic                        div8_next;
	logic [COUNT_W-1:0]          count_edge;
	logic [PSC_W-1:0]            psc_raw;
	logic [TMR_W-1:0]            psc_new;
	logic [COUNT_W-1:0]          rl_quo;
	logic [COUNT_W-1:0]          rl_adj;
	logic [TMR_W-1:0]            rl_new;
	logic                        load_out;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// gate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gate_q <= gtrs_pkg::GATE_RESET;
		else if (cfg_valid)
			gate_q <= gate_time_ms;
	end

	gtrs_serial_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_take),
		.a       (frequency_hz),
		.b       (gate_q),
		.done    (mul_done),
		.product (product)
	);

	// count checks, hysteresis and prescale from the first quotient
	always_comb begin
		reject     = div_quo >= gtrs_pkg::COUNT_LIMIT;
		count      = div_quo[COUNT_W-1:0];
		if (count > gtrs_pkg::HYST_HIGH)
			div8_next = 1'b1;
		else if (count < gtrs_pkg::HYST_LOW)
			div8_next = 1'b0;
		else
			div8_next = div8_q;
		count_edge = div8_next ? (count >> gtrs_pkg::EDGE_SHIFT) : count;
		psc_raw    = count_edge[COUNT_W-1:gtrs_pkg::PSC_SHIFT];
		psc_new    = (psc_raw == '0) ? TMR_W'(1) : TMR_W'(psc_raw);
	end

	// reload from the second quotient: minus one above 1, at least 1
	always_comb begin
		rl_quo = div_quo[COUNT_W-1:0];
		if (rl_quo > COUNT_W'(1))
			rl_adj = rl_quo - COUNT_W'(1);
		else
			rl_adj = COUNT_W'(1);
		rl_new = rl_adj[TMR_W-1:0];
	end

	// divider operand select: by 1000 after the product, then by prescale + 1
	always_comb begin
		div_start = 1'b0;
		if (state_q == ST_MUL && mul_done)
			div_start = 1'b1;
		else if (state_q == ST_DIV1 && div_done && !reject)
			div_start = 1'b1;
		if (state_q == ST_MUL) begin
			div_dividend = product;
			div_divisor  = gtrs_pkg::DIV_THOUSAND;
		end else begin
			div_dividend = PROD_W'(count_edge);
			div_divisor  = psc_new + TMR_W'(1);
		end
	end

	gtrs_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// sequencer and stored settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div8_q    <= 1'b1;
			psc_q     <= gtrs_pkg::PSC_RESET;
			reload_q  <= gtrs_pkg::RELOAD_RESET;
			res_acc_q <= 1'b0;
			res_chg_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done)
						state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done) begin
						if (reject) begin
							res_acc_q <= 1'b0;
							res_chg_q <= 1'b0;
							state_q   <= ST_OUT;
						end else begin
							div8_q  <= div8_next;
							state_q <= ST_DIV2;
						end
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						res_acc_q <= 1'b1;
						res_chg_q <= (new_psc_q != psc_q) || (rl_new != reload_q);
						psc_q     <= new_psc_q;
						reload_q  <= rl_new;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// new prescale held while the reload division runs
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV1 && div_done)
			new_psc_q <= psc_new;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_acc_q    <= res_acc_q;
			out_div8_q   <= div8_q;
			out_psc_q    <= psc_q;
			out_reload_q <= reload_q;
			out_chg_q    <= res_chg_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = out_acc_q;
	assign divide_by_eight = out_div8_q;
	assign timer_prescale  = out_psc_q;
	assign timer_reload    = out_reload_q;
	assign changed         = out_chg_q;

endmodule
`default_nettype wire
